FILE: src/tbu_pkg.sv
package tbu_pkg;

  localparam logic [15:0] TAG_BUNDLE = 16'h1234;
  localparam logic [15:0] TAG_NAME   = 16'h0101;
  localparam logic [15:0] TAG_DATA   = 16'h0202;

  localparam logic [2:0] HDR_LAST = 3'd7;

  // byte classes
  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_RHDR    = 3'd1;
  localparam logic [2:0] KIND_NAME    = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_SKIP    = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  // status codes
  localparam logic [3:0] ST_RUNNING    = 4'd0;
  localparam logic [3:0] ST_SUCCESS    = 4'd1;
  localparam logic [3:0] ST_SHORT_FILE = 4'd2;
  localparam logic [3:0] ST_BAD_HDR    = 4'd3;
  localparam logic [3:0] ST_SHORT_RHDR = 4'd4;
  localparam logic [3:0] ST_BAD_NAMELEN = 4'd5;
  localparam logic [3:0] ST_SHORT_NAME = 4'd6;
  localparam logic [3:0] ST_NO_NAME    = 4'd7;
  localparam logic [3:0] ST_SHORT_DATA = 4'd8;
  localparam logic [3:0] ST_SHORT_SKIP = 4'd9;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_RHDR = 6'b000010,
    PH_NAME = 6'b000100,
    PH_DATA = 6'b001000,
    PH_SKIP = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  // classified word passed from parser to output stage; strobes not yet gated
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       name_last;
    logic       open_req;
    logic       close_req;
    logic       wr_req;
    logic [3:0] status;
  } item_t;

endpackage

FILE: src/tbu_front.sv
module tbu_front
  import tbu_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       push,
  output item_t      push_item,
  input  logic       q_ready
);

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [15:0] tag_shift, tag_shift_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        name_seen, name_seen_next;
  logic [3:0]  error_code, error_code_next;

  logic [15:0] tag_upd;
  logic [31:0] len_upd;
  logic [2:0]  hc_upd;
  logic        hdr_done;
  logic        last_left;
  item_t       it;

  assign in_ready  = q_ready;
  assign push      = in_valid && q_ready;
  assign push_item = it;

  always_comb begin
    hdr_done  = (header_count == HDR_LAST);
    hc_upd    = hdr_done ? 3'd0 : header_count + 3'd1;
    tag_upd   = (header_count < 3'd2) ? {in_byte, tag_shift[15:8]} : tag_shift;
    len_upd   = (header_count >= 3'd4) ? {in_byte, length_shift[31:8]} : length_shift;
    last_left = (bytes_left == 32'd1);

    phase_next        = phase;
    header_count_next = header_count;
    tag_shift_next    = tag_shift;
    length_shift_next = length_shift;
    bytes_left_next   = bytes_left;
    name_seen_next    = name_seen;
    error_code_next   = error_code;

    it           = '0;
    it.value     = in_byte;
    it.kind      = KIND_IGNORED;

    unique case (phase)
      PH_HDR: begin
        it.kind           = KIND_HDR;
        tag_shift_next    = tag_upd;
        length_shift_next = len_upd;
        header_count_next = hc_upd;
        if (hdr_done) begin
          if (tag_upd != TAG_BUNDLE || len_upd != 32'd0) begin
            error_code_next = ST_BAD_HDR;
            phase_next      = PH_ERR;
          end else begin
            phase_next = PH_RHDR;
          end
        end
      end
      PH_RHDR: begin
        it.kind           = KIND_RHDR;
        tag_shift_next    = tag_upd;
        length_shift_next = len_upd;
        header_count_next = hc_upd;
        if (hdr_done) begin
          if (tag_upd == TAG_NAME) begin
            if (len_upd == 32'd0 || len_upd > 32'(MAX_NAME_LEN)) begin
              error_code_next = ST_BAD_NAMELEN;
              phase_next      = PH_ERR;
            end else begin
              bytes_left_next = len_upd;
              phase_next      = PH_NAME;
            end
          end else if (tag_upd == TAG_DATA) begin
            if (!name_seen) begin
              error_code_next = ST_NO_NAME;
              phase_next      = PH_ERR;
            end else begin
              it.open_req = 1'b1;
              if (len_upd == 32'd0) begin
                it.close_req = 1'b1;
              end else begin
                bytes_left_next = len_upd;
                phase_next      = PH_DATA;
              end
            end
          end else if (len_upd != 32'd0) begin
            bytes_left_next = len_upd;
            phase_next      = PH_SKIP;
          end
        end
      end
      PH_NAME: begin
        it.kind = KIND_NAME;
        // first name byte: a zero byte means an empty name
        if (bytes_left == length_shift) name_seen_next = (in_byte != 8'd0);
        bytes_left_next = bytes_left - 32'd1;
        if (last_left) begin
          it.name_last = 1'b1;
          phase_next   = PH_RHDR;
        end
      end
      PH_DATA: begin
        it.kind         = KIND_DATA;
        it.wr_req       = 1'b1;
        bytes_left_next = bytes_left - 32'd1;
        if (last_left) begin
          it.close_req = 1'b1;
          phase_next   = PH_RHDR;
        end
      end
      PH_SKIP: begin
        it.kind         = KIND_SKIP;
        bytes_left_next = bytes_left - 32'd1;
        if (last_left) phase_next = PH_RHDR;
      end
      PH_ERR: begin
        it.kind = KIND_IGNORED;
      end
      default: begin
        it.kind = KIND_IGNORED;
      end
    endcase

    it.status = error_code_next;
    if (last_byte) begin
      if (error_code_next == ST_RUNNING) begin
        unique case (phase_next)
          PH_HDR:  it.status = ST_SHORT_FILE;
          PH_RHDR: it.status = (header_count_next == 3'd0) ? ST_SUCCESS : ST_SHORT_RHDR;
          PH_NAME: it.status = ST_SHORT_NAME;
          PH_DATA: begin
            it.status    = ST_SHORT_DATA;
            it.close_req = 1'b1;
          end
          PH_SKIP: it.status = ST_SHORT_SKIP;
          PH_ERR:  it.status = ST_SUCCESS;
          default: it.status = ST_SUCCESS;
        endcase
      end
      // end of bundle: start over
      phase_next        = PH_HDR;
      header_count_next = 3'd0;
      tag_shift_next    = 16'd0;
      length_shift_next = 32'd0;
      bytes_left_next   = 32'd0;
      name_seen_next    = 1'b0;
      error_code_next   = ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      header_count <= 3'd0;
      tag_shift    <= 16'd0;
      length_shift <= 32'd0;
      bytes_left   <= 32'd0;
      name_seen    <= 1'b0;
      error_code   <= ST_RUNNING;
    end else if (push) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      tag_shift    <= tag_shift_next;
      length_shift <= length_shift_next;
      bytes_left   <= bytes_left_next;
      name_seen    <= name_seen_next;
      error_code   <= error_code_next;
    end
  end

  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_RUNNING) == (phase == PH_ERR))
    else $error("error code and error phase disagree");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR && push && !last_byte) |=> (phase == PH_ERR))
    else $error("error phase left before end of bundle");

  a_payload_hc: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME || phase == PH_DATA || phase == PH_SKIP) |-> (header_count == 3'd0))
    else $error("header count not clear during payload");

endmodule

FILE: src/tbu_queue.sv
module tbu_queue
  import tbu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  q_ready,
  input  logic  pop,
  output item_t pop_item,
  output logic  q_valid
);

  item_t           mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  count;

  assign q_ready  = (count != QCW'(QDEPTH));
  assign q_valid  = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop)      count <= count + QCW'(1);
      else if (pop && !push) count <= count - QCW'(1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: src/tbu_back.sv
module tbu_back
  import tbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       q_valid,
  input  item_t      pop_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] byte_kind,
  output logic [7:0] byte_value,
  output logic       name_last,
  output logic       file_open,
  output logic       file_close,
  output logic       write_strobe,
  output logic [3:0] status
);

  logic write_out;

  assign cfg_ready = 1'b1;
  assign pop       = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      write_out <= 1'b1;
    end else begin
      if (cfg_valid) write_out <= cfg_data;
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // strobes only go out when writing is enabled
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_kind    <= pop_item.kind;
      byte_value   <= pop_item.value;
      name_last    <= pop_item.name_last;
      file_open    <= pop_item.open_req && write_out;
      file_close   <= pop_item.close_req && write_out;
      write_strobe <= pop_item.wr_req && write_out;
      status       <= pop_item.status;
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output word dropped without handshake");

endmodule

FILE: src/tlv_bundle_unpacker.sv
// Channel  | handshake            | payload
// in       | in_valid / in_ready  | in_byte[7:0], last_byte
// out      | out_valid/ out_ready | byte_kind, byte_value, name_last, file_open,
//          |                      | file_close, write_strobe, status
// cfg      | cfg_valid/ cfg_ready | cfg_data (write_out)
//
// One byte per cycle sustained while out is not stalled; a taken byte is
// written into the queue at the accepting edge, then into the output register.
// The parser state loop advances once per accepted byte; that sets the rate.
// Synchronous active-high rst clears the parser, queue and output stage;
// write_out resets to 1. cfg_ready is always high.
// An out stall fills the two-entry queue, then drops in_ready.
module tlv_bundle_unpacker
  import tbu_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] byte_kind,
  output logic [7:0] byte_value,
  output logic       name_last,
  output logic       file_open,
  output logic       file_close,
  output logic       write_strobe,
  output logic [3:0] status
);

  logic  push;
  logic  pop;
  logic  q_ready;
  logic  q_valid;
  item_t push_item;
  item_t pop_item;

  tbu_front #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  tbu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_valid   (q_valid)
  );

  tbu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_kind    (byte_kind),
    .byte_value   (byte_value),
    .name_last    (name_last),
    .file_open    (file_open),
    .file_close   (file_close),
    .write_strobe (write_strobe),
    .status       (status)
  );

endmodule

FILE: tb/tb_tlv_bundle_unpacker.sv
module tb_tlv_bundle_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import tbu_pkg::*;

  localparam int MAX_NAME_LEN   = 63;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NDIR           = 35;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       name_last;
    logic       f_open;
    logic       f_close;
    logic       wr;
    logic [3:0] status;
  } unpack_word_t;

  // kind and status columns are only read on rows with typed set
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    logic [2:0] kind;
    logic [3:0] status;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [NDIR] = '{
    // bundle header, good
    '{8'h34, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h12, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_HDR, ST_RUNNING},
    // name record, length 1, reserved byte all ones
    '{8'h01, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h01, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'hFF, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h01, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h41, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    // empty data record: open and close on the same byte
    '{8'h02, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h02, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, KIND_HDR, ST_RUNNING},
    // name record with zero length, then a sticky error to the end
    '{8'h01, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h01, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, KIND_RHDR, ST_BAD_NAMELEN},
    '{8'hFF, 1'b1, 1'b1, KIND_IGNORED, ST_BAD_NAMELEN},
    // one-byte bundle
    '{8'hA5, 1'b1, 1'b1, KIND_HDR, ST_SHORT_FILE}
  };

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] byte_kind;
  logic [7:0] byte_value;
  logic       name_last;
  logic       file_open;
  logic       file_close;
  logic       write_strobe;
  logic [3:0] status;

  // parser state mirror
  phase_t      m_phase;
  logic [2:0]  m_hcnt;
  logic [15:0] m_tag;
  logic [31:0] m_len;
  logic [31:0] m_left;
  logic        m_named;
  logic [3:0]  m_err;
  logic        m_write_out;

  unpack_word_t due_q [$];
  unpack_word_t due_w;
  logic [7:0]   bundle_q [$];
  int           fails = 0;
  int           words_seen = 0;
  int           useful_sent = 0;
  int           calm_in = 0;
  int           quiet_cycles = 0;

  tlv_bundle_unpacker #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_kind   (byte_kind),
    .byte_value  (byte_value),
    .name_last   (name_last),
    .file_open   (file_open),
    .file_close  (file_close),
    .write_strobe(write_strobe),
    .status      (status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void clear_parse_state();
    m_phase = PH_HDR;
    m_hcnt  = '0;
    m_tag   = '0;
    m_len   = '0;
    m_left  = '0;
    m_named = 1'b0;
    m_err   = ST_RUNNING;
  endfunction

  function automatic unpack_word_t unpack_byte(input logic [7:0] b, input logic lst);
    unpack_word_t w;
    logic hdr_done;
    w = '0;
    w.kind = KIND_IGNORED;
    w.value = b;
    hdr_done = 1'b0;
    // tag in bytes 0-1, length in bytes 4-7, both little-endian
    if (m_phase == PH_HDR || m_phase == PH_RHDR) begin
      if (m_hcnt < 3'd2) begin
        m_tag = {b, m_tag[15:8]};
      end else if (m_hcnt >= 3'd4) begin
        m_len = {b, m_len[31:8]};
      end
      hdr_done = (m_hcnt == HDR_LAST);
      m_hcnt = hdr_done ? 3'd0 : m_hcnt + 3'd1;
    end
    case (m_phase)
      PH_HDR: begin
        w.kind = KIND_HDR;
        if (hdr_done) begin
          if (m_tag != TAG_BUNDLE || m_len != 0) begin
            m_err = ST_BAD_HDR;
            m_phase = PH_ERR;
          end else begin
            m_phase = PH_RHDR;
          end
        end
      end
      PH_RHDR: begin
        w.kind = KIND_RHDR;
        if (hdr_done) begin
          if (m_tag == TAG_NAME) begin
            if (m_len == 0 || m_len > MAX_NAME_LEN) begin
              m_err = ST_BAD_NAMELEN;
              m_phase = PH_ERR;
            end else begin
              m_left = m_len;
              m_phase = PH_NAME;
            end
          end else if (m_tag == TAG_DATA) begin
            if (!m_named) begin
              m_err = ST_NO_NAME;
              m_phase = PH_ERR;
            end else begin
              w.f_open = m_write_out;
              if (m_len == 0) begin
                w.f_close = m_write_out;
              end else begin
                m_left = m_len;
                m_phase = PH_DATA;
              end
            end
          end else if (m_len != 0) begin
            m_left = m_len;
            m_phase = PH_SKIP;
          end
        end
      end
      PH_NAME: begin
        w.kind = KIND_NAME;
        // a name starting with a zero byte counts as empty
        if (m_left == m_len) m_named = (b != 8'h00);
        m_left = m_left - 1;
        if (m_left == 0) begin
          w.name_last = 1'b1;
          m_phase = PH_RHDR;
        end
      end
      PH_DATA: begin
        w.kind = KIND_DATA;
        w.wr = m_write_out;
        m_left = m_left - 1;
        if (m_left == 0) begin
          w.f_close = m_write_out;
          m_phase = PH_RHDR;
        end
      end
      PH_SKIP: begin
        w.kind = KIND_SKIP;
        m_left = m_left - 1;
        if (m_left == 0) m_phase = PH_RHDR;
      end
      default: ;
    endcase
    w.status = m_err;
    if (lst) begin
      if (m_err == ST_RUNNING) begin
        case (m_phase)
          PH_HDR:  w.status = ST_SHORT_FILE;
          PH_RHDR: w.status = (m_hcnt == 0) ? ST_SUCCESS : ST_SHORT_RHDR;
          PH_NAME: w.status = ST_SHORT_NAME;
          PH_DATA: begin
            w.status = ST_SHORT_DATA;
            w.f_close = m_write_out;
          end
          PH_SKIP: w.status = ST_SHORT_SKIP;
          default: w.status = ST_SUCCESS;
        endcase
      end
      clear_parse_state();
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fails++;
    end
  endfunction

  // valid stays high after a word is taken; the next call or the caller lowers it
  task automatic send_word(input logic [7:0] b, input logic lst);
    int gap;
    if (calm_in > 0) begin
      gap = 0;
      calm_in--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 149) == 0) calm_in = $urandom_range(30, 90);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(input logic v);
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_write_out = v;
  endtask

  task automatic push_hdr(input logic [15:0] tag, input logic [31:0] len);
    int k;
    bundle_q.push_back(tag[7:0]);
    bundle_q.push_back(tag[15:8]);
    bundle_q.push_back(8'($urandom));
    bundle_q.push_back(8'($urandom));
    for (k = 0; k < 4; k++) bundle_q.push_back(len[8*k +: 8]);
  endtask

  task automatic push_payload(input int unsigned n, input bit zero_first);
    int unsigned k;
    for (k = 0; k < n; k++) bundle_q.push_back((k == 0 && zero_first) ? 8'h00 : 8'($urandom));
  endtask

  task automatic build_bundle();
    int pick, nrec, r, k, cut;
    logic [31:0] len;
    bundle_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 20)) bundle_q.push_back(8'($urandom));
      return;
    end
    if (pick < 12) begin
      push_hdr($urandom_range(0, 1) ? TAG_BUNDLE : 16'($urandom), 32'd1 << $urandom_range(0, 31));
    end else begin
      push_hdr(TAG_BUNDLE, 32'd0);
    end
    nrec = $urandom_range(0, 6);
    for (k = 0; k < nrec; k++) begin
      r = $urandom_range(0, 99);
      if (k == 0 && r < 70) r = 0;
      if (r < 30) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 8);
        else if (r < 90) len = MAX_NAME_LEN;
        else if (r < 96) len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_NAME_LEN + 1, 255);
        else len = $urandom;
        push_hdr(TAG_NAME, len);
        if (len == 0 || len > MAX_NAME_LEN) begin
          push_payload($urandom_range(0, 4), 1'b0);
          break;
        end
        push_payload(len, $urandom_range(0, 5) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) len = 0;
        else if (r < 88) len = $urandom_range(1, 16);
        else if (r < 97) len = $urandom_range(17, 200);
        else len = $urandom;
        push_hdr(($urandom_range(0, 99) < 55) ? TAG_DATA : 16'($urandom), len);
        // huge record: only a few bytes, cut off by the end of the bundle
        if (len > 200) begin
          push_payload($urandom_range(0, 10), 1'b0);
          break;
        end
        push_payload(len, 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 12 && bundle_q.size() > 1) begin
      cut = $urandom_range(1, bundle_q.size() - 1);
      while (bundle_q.size() > cut) void'(bundle_q.pop_back());
    end
  endtask

  task automatic run_bundles(input int n_items);
    int stop_at, k;
    unpack_word_t w;
    stop_at = useful_sent + n_items;
    while (useful_sent < stop_at) begin
      build_bundle();
      for (k = 0; k < bundle_q.size(); k++) begin
        send_word(bundle_q[k], k == bundle_q.size() - 1);
        w = unpack_byte(bundle_q[k], k == bundle_q.size() - 1);
        due_q.push_back(w);
        useful_sent++;
      end
    end
  endtask

  initial begin : stimulus
    int i;
    unpack_word_t w;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    last_byte = 1'b0;
    m_write_out = 1'b1;
    clear_parse_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NDIR; i++) begin
      send_word(DIR_TAB[i].b, DIR_TAB[i].lst);
      w = unpack_byte(DIR_TAB[i].b, DIR_TAB[i].lst);
      if (DIR_TAB[i].typed) begin
        w = '0;
        w.kind = DIR_TAB[i].kind;
        w.value = DIR_TAB[i].b;
        w.status = DIR_TAB[i].status;
      end
      due_q.push_back(w);
    end

    write_cfg(1'b0);
    run_bundles(550);
    write_cfg(1'b1);
    run_bundles(550);
    write_cfg(1'b0);
    run_bundles(550);
    in_valid <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the input side backs up
  initial begin : rx_side
    int g;
    int calm_out;
    bit held;
    out_ready = 1'b0;
    calm_out = 0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && words_seen >= 300) begin
        g = LONG_HOLD;
        held = 1'b1;
      end else if (calm_out > 0) begin
        g = 0;
        calm_out--;
      end else begin
        g = pick_gap();
        if ($urandom_range(0, 149) == 0) calm_out = $urandom_range(30, 90);
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (due_q.size() == 0) begin
        $error("byte_value: expected no word, got %0d", byte_value);
        fails++;
      end else begin
        due_w = due_q.pop_front();
        check_field("byte_kind", due_w.kind, byte_kind);
        check_field("byte_value", due_w.value, byte_value);
        check_field("name_last", due_w.name_last, name_last);
        check_field("file_open", due_w.f_open, file_open);
        check_field("file_close", due_w.f_close, file_close);
        check_field("write_strobe", due_w.wr, write_strobe);
        check_field("status", due_w.status, status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: tlv_bundle_unpacker.f
src/tbu_pkg.sv
src/tbu_front.sv
src/tbu_queue.sv
src/tbu_back.sv
src/tlv_bundle_unpacker.sv
tb/tb_tlv_bundle_unpacker.sv
